[rtl/tea_pkg.sv]
// TEA block cipher package: widths, register indexes, constants and the round function.
// Used by tea_round_pipe, tea_block_cipher_top and the testbench; depends on nothing.
package tea_pkg;

    localparam int WORD_W     = 32;
    localparam int ROUND_W    = 7;
    localparam int MAX_ROUNDS = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int STAGES     = 2 * MAX_ROUNDS;

    localparam logic [WORD_W-1:0]  TEA_DELTA     = 32'h9E3779B9;
    localparam logic [ROUND_W-1:0] ROUNDS_RESET  = 7'd32;

    localparam logic [CFG_IDX_W-1:0] REG_KEY0     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY1     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY2     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY3     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROUNDS   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_NET_ORD  = 3'd5;

    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    typedef logic [WORD_W-1:0] word_t;

    // One half-round payload that travels down the pipe
    typedef struct packed {
        logic                op;
        logic [ROUND_W-1:0]  rounds;
        logic                net;
        word_t               y;
        word_t               z;
        word_t               sum;
    } stage_t;

    function automatic word_t swap32(input word_t v);
        swap32 = {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

    // Mix function of one half round
    function automatic word_t mix(input word_t v, input word_t s,
                                  input word_t kl, input word_t kr);
        mix = ((v << 4) + kl) ^ (v + s) ^ ((v >> 5) + kr);
    endfunction

endpackage

[rtl/tea_if.sv]
// Valid/ready channel interface carrying a generic payload.
// Depends on nothing.
interface tea_if #(parameter int W = 1) ();
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/tea_round_pipe.sv]
// Unrolled TEA pipeline: one half round per stage, 128 stages, stall-able.
// Depends on tea_pkg.
module tea_round_pipe
    import tea_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   adv,
    input  logic   in_valid,
    input  stage_t in_data,
    input  word_t  key_a,
    input  word_t  key_b,
    input  word_t  key_c,
    input  word_t  key_d,
    output logic   out_valid,
    output stage_t out_data
);

    logic   vld_reg [STAGES+1];
    stage_t dat_reg [STAGES+1];

    always_comb
    begin
        vld_reg[0] = in_valid;
        dat_reg[0] = in_data;
    end

    // Each stage applies one half round when its round index is active
    for (genvar g = 0; g < STAGES; g++)
    begin : g_stage
        localparam int RIDX = g / 2;
        localparam logic [ROUND_W-1:0] RIDX_C = ROUND_W'(RIDX);
        stage_t cur;
        stage_t nxt;
        logic   act;
        word_t  s1;
        always_comb
        begin
            cur = dat_reg[g];
            nxt = cur;
            act = RIDX_C < cur.rounds;
            s1  = cur.sum + TEA_DELTA;
            if (act)
            begin
                if (cur.op == OP_ENCRYPT)
                begin
                    if ((g % 2) == 0)
                    begin
                        nxt.sum = s1;
                        nxt.y   = cur.y + mix(cur.z, s1, key_a, key_b);
                    end
                    else
                        nxt.z = cur.z + mix(cur.y, cur.sum, key_c, key_d);
                end
                else
                begin
                    if ((g % 2) == 0)
                        nxt.z = cur.z - mix(cur.y, cur.sum, key_c, key_d);
                    else
                    begin
                        nxt.y   = cur.y - mix(cur.z, cur.sum, key_a, key_b);
                        nxt.sum = cur.sum - TEA_DELTA;
                    end
                end
            end
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[g+1] <= 1'b0;
            else if (adv)
                vld_reg[g+1] <= vld_reg[g];
        end
        always_ff @(posedge clk)
        begin
            if (adv)
                dat_reg[g+1] <= nxt;
        end
    end

    assign out_valid = vld_reg[STAGES];
    assign out_data  = dat_reg[STAGES];

endmodule

[rtl/tea_block_cipher_top.sv]
// TEA block cipher top level: config registers, input prep, round pipe, output register.
// One beat per cycle sustained while the output is not stalled.
// The round pipe holds 128 half-round stages (64 rounds maximum), so rate is set by
// the single entry stage, and the configured round count only gates stages.
// Reset clears all valid bits; keys reset to 0, rounds to 32, byte order off.
// Depends on tea_pkg, tea_if and tea_round_pipe.
module tea_block_cipher_top
    import tea_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data,
    tea_if.sink                  in_ch,
    tea_if.source                out_ch
);

    word_t              key0_reg, key1_reg, key2_reg, key3_reg;
    logic [ROUND_W-1:0] rounds_reg;
    logic               net_reg;

    // Write config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key0_reg   <= '0;
            key1_reg   <= '0;
            key2_reg   <= '0;
            key3_reg   <= '0;
            rounds_reg <= ROUNDS_RESET;
            net_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_KEY0:    key0_reg   <= cfg_data;
                REG_KEY1:    key1_reg   <= cfg_data;
                REG_KEY2:    key2_reg   <= cfg_data;
                REG_KEY3:    key3_reg   <= cfg_data;
                REG_ROUNDS:  rounds_reg <= cfg_data[ROUND_W-1:0];
                REG_NET_ORD: net_reg    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    word_t key_a, key_b, key_c, key_d;
    assign key_a = net_reg ? swap32(key0_reg) : key0_reg;
    assign key_b = net_reg ? swap32(key1_reg) : key1_reg;
    assign key_c = net_reg ? swap32(key2_reg) : key2_reg;
    assign key_d = net_reg ? swap32(key3_reg) : key3_reg;

    // Output register and pipe advance
    logic   ovld_reg;
    word_t  of_reg, os_reg;
    logic   adv;
    logic   pv;
    stage_t pd;
    assign adv = !ovld_reg || out_ch.ready;
    assign in_ch.ready = adv;

    // Entry stage: byte order, clamp rounds, starting sum
    logic               op;
    word_t              wf, ws;
    logic [ROUND_W-1:0] rcl;
    stage_t             ent_reg;
    logic               evld_reg;
    assign op  = in_ch.data[2*WORD_W];
    assign wf  = in_ch.data[2*WORD_W-1:WORD_W];
    assign ws  = in_ch.data[WORD_W-1:0];
    assign rcl = (rounds_reg > ROUND_W'(MAX_ROUNDS)) ? ROUND_W'(MAX_ROUNDS) : rounds_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            evld_reg <= 1'b0;
        else if (adv)
            evld_reg <= in_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ent_reg.op     <= op;
            ent_reg.rounds <= rcl;
            ent_reg.net    <= net_reg;
            ent_reg.y      <= net_reg ? swap32(wf) : wf;
            ent_reg.z      <= net_reg ? swap32(ws) : ws;
            // delta * rounds: constant times a 7-bit value, a shift-add of narrow width
            ent_reg.sum    <= (op == OP_DECRYPT) ? word_t'(TEA_DELTA * {25'd0, rcl}) : '0;
        end
    end

    tea_round_pipe u_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (evld_reg),
        .in_data   (ent_reg),
        .key_a     (key_a),
        .key_b     (key_b),
        .key_c     (key_c),
        .key_d     (key_d),
        .out_valid (pv),
        .out_data  (pd)
    );

    // Hold result until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovld_reg <= 1'b0;
        else if (adv)
            ovld_reg <= pv;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            of_reg <= pd.net ? swap32(pd.y) : pd.y;
            os_reg <= pd.net ? swap32(pd.z) : pd.z;
        end
    end

    assign out_ch.valid = ovld_reg;
    assign out_ch.data  = {of_reg, os_reg};

    // A stalled result holds its value
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ovld_reg && !out_ch.ready |=> ovld_reg && $stable(of_reg) && $stable(os_reg))
        else $error("result changed under stall");
    // The pipe accepts exactly when the output can move
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready == (!ovld_reg || out_ch.ready))
        else $error("ready mismatch");
    // Entry stage never stalls without a waiting result
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |-> ovld_reg)
        else $error("stall without pending result");

endmodule

[sim/tb_tea_block_cipher_top.sv]
// Testbench for the TEA block cipher top level: directed table, then random phases.
// Depends on tea_pkg, tea_if and tea_block_cipher_top from the RTL folder.
module tb_tea_block_cipher_top;
    import tea_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE7 = 3'd7;
    localparam int DRAIN_CYCLES = 140;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_BLOCKS = 350;

    typedef struct packed {
        word_t first;
        word_t second;
    } block_t;

    typedef struct {
        logic               op;
        word_t              y;
        word_t              z;
        logic [ROUND_W-1:0] rounds;
        logic               net;
        bit                 fixed;
        block_t             result;
    } vec_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    word_t                cfg_data;

    tea_if #(.W(1 + 2 * WORD_W)) in_ch ();
    tea_if #(.W(2 * WORD_W))     out_ch ();

    tea_block_cipher_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .in_ch    (in_ch),
        .out_ch   (out_ch)
    );

    // Shadow of the configuration registers
    word_t              key_q [4];
    logic [ROUND_W-1:0] rounds_q;
    logic               net_q;

    block_t pending_blocks[$];
    int     errors;
    int     cycles;
    int     idle_pct;
    int     stall_pct;
    int     hold_token;
    int     hold_seen;
    int     hold_left;

    initial clk = 1'b0;
    always #1 clk = ~clk;

    function automatic word_t bswap(input word_t v, input logic en);
        return en ? {v[7:0], v[15:8], v[23:16], v[31:24]} : v;
    endfunction

    // Expected cipher output under the shadow configuration
    function automatic block_t tea_cipher(input logic op, input word_t yin, input word_t zin);
        word_t  y, z, a, b, c, d, s;
        int     nr;
        block_t r;
        y  = bswap(yin, net_q);
        z  = bswap(zin, net_q);
        a  = bswap(key_q[0], net_q);
        b  = bswap(key_q[1], net_q);
        c  = bswap(key_q[2], net_q);
        d  = bswap(key_q[3], net_q);
        nr = (rounds_q > MAX_ROUNDS) ? MAX_ROUNDS : int'(rounds_q);
        if (op == OP_ENCRYPT)
        begin
            s = '0;
            for (int i = 0; i < nr; i++)
            begin
                s = s + TEA_DELTA;
                y = y + (((z << 4) + a) ^ (z + s) ^ ((z >> 5) + b));
                z = z + (((y << 4) + c) ^ (y + s) ^ ((y >> 5) + d));
            end
        end
        else
        begin
            s = TEA_DELTA * word_t'(nr);
            for (int i = 0; i < nr; i++)
            begin
                z = z - (((y << 4) + c) ^ (y + s) ^ ((y >> 5) + d));
                y = y - (((z << 4) + a) ^ (z + s) ^ ((z >> 5) + b));
                s = s - TEA_DELTA;
            end
        end
        r.first  = bswap(y, net_q);
        r.second = bswap(z, net_q);
        return r;
    endfunction

    // Drive one register beat; the caller lowers the enable afterwards
    task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input word_t val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: key_q[idx[1:0]] = val;
            REG_ROUNDS:  rounds_q = val[ROUND_W-1:0];
            REG_NET_ORD: net_q = val[0];
            default: ;
        endcase
    endtask

    task automatic reg_release();
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Wait for every expected block, then let the pipe settle
    task automatic drain();
        while (pending_blocks.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Offer one block and hold it until accepted
    task automatic send_block(input logic op, input word_t y, input word_t z,
                              input bit fixed, input block_t result);
        if ($urandom_range(99) < idle_pct)
        begin
            in_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= {op, y, z};
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        pending_blocks.push_back(fixed ? result : tea_cipher(op, y, z));
    endtask

    task automatic stop_sending();
        in_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic word_t rand_word();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2:       return word_t'(1) << $urandom_range(31);
            default: return $urandom();
        endcase
    endfunction

    // Receiver: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_token != hold_seen)
        begin
            hold_seen    <= hold_token;
            hold_left    <= HOLD_CYCLES;
            out_ch.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left    <= hold_left - 1;
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // Compare each output beat with the oldest expected block
    always @(posedge clk)
    begin
        block_t got, want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = out_ch.data;
            if (pending_blocks.size() == 0)
            begin
                $display("%0t: unexpected block %h %h", $time, got.first, got.second);
                errors++;
            end
            else
            begin
                want = pending_blocks.pop_front();
                if (got.first !== want.first)
                begin
                    $display("%0t: result_first expected %h actual %h",
                             $time, want.first, got.first);
                    errors++;
                end
                if (got.second !== want.second)
                begin
                    $display("%0t: result_second expected %h actual %h",
                             $time, want.second, got.second);
                    errors++;
                end
            end
        end
    end

    // Run guard
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    vec_t dir_tab[$];

    function automatic vec_t row(input logic op, input word_t y, input word_t z,
                                 input int rnd, input logic net, input bit fixed,
                                 input word_t r1, input word_t r2);
        vec_t v;
        v.op = op; v.y = y; v.z = z; v.rounds = rnd[ROUND_W-1:0]; v.net = net;
        v.fixed = fixed; v.result = {r1, r2};
        return v;
    endfunction

    initial
    begin
        int     rnd_sel;
        logic   op;
        word_t  y, z;
        block_t last;

        errors     = 0;
        cycles     = 0;
        idle_pct   = 0;
        stall_pct  = 0;
        hold_token = 0;
        hold_seen  = 0;
        hold_left  = 0;
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        out_ch.ready = 1'b0;
        key_q      = '{default: '0};
        rounds_q   = ROUNDS_RESET;
        net_q      = 1'b0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: reset keys, extremes, zero and excess round counts, byte order
        dir_tab.push_back(row(OP_ENCRYPT, 32'h0, 32'h0, 32, 0, 1, 32'h41EA3A0A, 32'h94BAA940));
        dir_tab.push_back(row(OP_DECRYPT, 32'h41EA3A0A, 32'h94BAA940, 32, 0, 1, 32'h0, 32'h0));
        dir_tab.push_back(row(OP_ENCRYPT, '1, '1, 32, 0, 0, 0, 0));
        dir_tab.push_back(row(OP_DECRYPT, '1, 32'h0, 32, 0, 0, 0, 0));
        dir_tab.push_back(row(OP_ENCRYPT, 32'h0, '1, 32, 0, 0, 0, 0));
        dir_tab.push_back(row(OP_ENCRYPT, 32'hDEADBEEF, 32'h01234567, 0, 0, 1,
                              32'hDEADBEEF, 32'h01234567));
        dir_tab.push_back(row(OP_DECRYPT, '1, 32'h0, 0, 0, 1, '1, 32'h0));
        dir_tab.push_back(row(OP_ENCRYPT, 32'h80000000, 32'h00000001, 1, 0, 0, 0, 0));
        dir_tab.push_back(row(OP_DECRYPT, 32'h80000000, 32'h00000001, 1, 0, 0, 0, 0));
        dir_tab.push_back(row(OP_ENCRYPT, 32'h12345678, 32'h9ABCDEF0, 64, 0, 0, 0, 0));
        dir_tab.push_back(row(OP_DECRYPT, 32'h12345678, 32'h9ABCDEF0, 64, 0, 0, 0, 0));
        dir_tab.push_back(row(OP_ENCRYPT, 32'h12345678, 32'h9ABCDEF0, 127, 0, 0, 0, 0));
        dir_tab.push_back(row(OP_DECRYPT, '1, '1, 65, 0, 0, 0, 0));
        dir_tab.push_back(row(OP_ENCRYPT, 32'h01020304, 32'hA0B0C0D0, 32, 1, 0, 0, 0));
        dir_tab.push_back(row(OP_DECRYPT, 32'h01020304, 32'hA0B0C0D0, 32, 1, 0, 0, 0));
        dir_tab.push_back(row(OP_ENCRYPT, 32'h0, 32'h0, 0, 1, 1, 32'h0, 32'h0));

        foreach (dir_tab[i])
        begin
            if (dir_tab[i].rounds != rounds_q || dir_tab[i].net != net_q)
            begin
                stop_sending();
                drain();
                reg_write(REG_ROUNDS, word_t'(dir_tab[i].rounds));
                reg_write(REG_NET_ORD, word_t'(dir_tab[i].net));
                reg_release();
            end
            send_block(dir_tab[i].op, dir_tab[i].y, dir_tab[i].z,
                       dir_tab[i].fixed, dir_tab[i].result);
        end
        stop_sending();
        drain();

        // Random phases, each with its own keys, round count, byte order and idling
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  rnd_sel = 32;  end
                1: begin idle_pct = 57; stall_pct = 0;  rnd_sel = 64;  end
                2: begin idle_pct = 0;  stall_pct = 57; rnd_sel = 1;   end
                3: begin idle_pct = 35; stall_pct = 35; rnd_sel = 127; end
                default: begin idle_pct = 0; stall_pct = 0; rnd_sel = $urandom_range(127); end
            endcase
            for (int k = 0; k < 4; k++)
                reg_write(k[CFG_IDX_W-1:0], (ph == 1) ? '1 : $urandom());
            // Upper bits of narrow registers drop; spare indexes are ignored
            reg_write(REG_ROUNDS, {25'($urandom_range(32'h1FFFFFF)), rnd_sel[ROUND_W-1:0]});
            reg_write(REG_NET_ORD, {31'($urandom_range(32'h7FFFFFFF)), ph[0]});
            reg_write(REG_SPARE6, $urandom());
            reg_write(REG_SPARE7, $urandom());
            reg_release();

            last = '0;
            for (int n = 0; n < PHASE_BLOCKS; n++)
            begin
                // Request a long hold-off mid-phase so the pipe backs up
                if (ph == 4 && n == 20)
                    hold_token++;
                op = $urandom_range(1);
                if ($urandom_range(3) == 0)
                begin
                    // Round trip: feed back what was just produced, under a random operation
                    y = last.first;
                    z = last.second;
                end
                else
                begin
                    y = rand_word();
                    z = rand_word();
                end
                send_block(op, y, z, 0, '0);
                last = tea_cipher(op, y, z);
            end
            stop_sending();
            drain();
        end

        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

[filelist.f]
rtl/tea_pkg.sv
rtl/tea_if.sv
rtl/tea_round_pipe.sv
rtl/tea_block_cipher_top.sv
sim/tb_tea_block_cipher_top.sv
